@@ design/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared types and constants for the sorted cell row and its control.
// ----------------------------------------------------------------------------
package swm_pkg;

  // Width of the window length register
  localparam int unsigned LEN_W = 9;

  // Configuration port geometry
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  // Register index of window_len
  localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_RED  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  // Broadcast control to every cell of the row
  typedef struct packed {
    logic flush;  // empty the row
    logic upd;    // apply one evict/insert step
    logic del;    // window full: evict the oldest value
    logic up;     // new sample >= evicted value
  } cell_ctrl_t;

endpackage

@@ design/swm_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted row cell
// Holds one window value; the row stays sorted ascending with empty cells on
// top. Each step a cell keeps its value, takes a neighbor's or the new sample.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int unsigned W = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swm_pkg::cell_ctrl_t    ctrl_i,
  input  logic [W-1:0]           sample_i,
  input  logic [W-1:0]           vold_i,
  input  logic                   prv_vld_i,
  input  logic [W-1:0]           prv_val_i,
  input  logic                   prv_a_i,
  input  logic                   prv_b_i,
  input  logic                   nxt_vld_i,
  input  logic [W-1:0]           nxt_val_i,
  input  logic                   nxt_b_i,
  output logic                   vld_o,
  output logic [W-1:0]           val_o,
  output logic                   a_o,
  output logic                   b_o
);

  logic         vld_q, vld_d;
  logic [W-1:0] val_q, val_d;

  // At or above the eviction point / above the insertion point
  assign a_o   = !vld_q || (val_q >= vold_i);
  assign b_o   = !vld_q || (val_q > sample_i);
  assign vld_o = vld_q;
  assign val_o = val_q;

  // Pick the source for this cell
  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctrl_i.flush) begin
      vld_d = 1'b0;
    end else if (ctrl_i.upd) begin
      if (ctrl_i.del && ctrl_i.up) begin
        // evict below, insert above: shift down between the two points
        if (a_o && !nxt_b_i) begin
          vld_d = nxt_vld_i;
          val_d = nxt_val_i;
        end else if (a_o && !b_o) begin
          vld_d = 1'b1;
          val_d = sample_i;
        end
      end else if (ctrl_i.del) begin
        // insert below, evict above: shift up between the two points
        if (b_o && !prv_b_i) begin
          vld_d = 1'b1;
          val_d = sample_i;
        end else if (b_o && !prv_a_i) begin
          vld_d = prv_vld_i;
          val_d = prv_val_i;
        end
      end else begin
        // insert only: shift up above the insertion point
        if (b_o && !prv_b_i) begin
          vld_d = 1'b1;
          val_d = sample_i;
        end else if (b_o) begin
          vld_d = prv_vld_i;
          val_d = prv_val_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

@@ design/swm_tap_reduce.sv @@
// ----------------------------------------------------------------------------
// Median tap reduction
// ORs the masked cell taps in groups of sixteen into registers; the group
// results are ORed once more into the value presented at the output.
// ----------------------------------------------------------------------------
module swm_tap_reduce #(
  parameter int unsigned N = 256,
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic [W-1:0] tap_i [N],
  output logic [W-1:0] val_o
);

  localparam int unsigned GRP  = 16;
  localparam int unsigned NGRP = (N + GRP - 1) / GRP;

  logic [W-1:0] grp_q [NGRP];
  logic [W-1:0] grp_d [NGRP];

  // First level: one OR per group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < N) begin
          grp_d[g] = grp_d[g] | tap_i[g * GRP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  // Second level: OR of the group registers
  always_comb begin
    val_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      val_o = val_o | grp_q[g];
    end
  end

endmodule

@@ design/sliding_window_median_core.sv @@
// ----------------------------------------------------------------------------
// Sliding window median core
// Per sample: capture it and read the oldest stored value, step the sorted
// cell row, then, if a median is due, register the tap OR groups and load the
// median word once the output is free; the next sample waits for idle.
// Reset: cell row empty, window length 3, no clearing pass; a window_len write
// empties the window the same way.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // sample stream in
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  // median stream out
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata,   // [SAMPLE_BITS-1:0] median
  // configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [swm_pkg::APB_AW-1:0]             paddr,
  input  logic [swm_pkg::APB_DW-1:0]             pwdata,
  output logic [swm_pkg::APB_DW-1:0]             prdata,
  output logic                                   pready
);

  localparam int unsigned SB      = SAMPLE_BITS;
  localparam int unsigned TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  swm_pkg::state_e            state_q, state_d;
  logic [swm_pkg::LEN_W-1:0]  len_q;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [PTR_W-1:0]           oldest_q, oldest_d;
  logic                       full_q;
  logic [SB-1:0]              smp_q;
  logic [SB-1:0]              rd_q;
  logic [SB-1:0]              mem [MAX_WINDOW];
  logic [CNT_W-1:0]           eff_len;
  logic [CNT_W-1:0]           kidx;
  logic [CNT_W-1:0]           fill_inc;
  logic [CNT_W-1:0]           oldest_inc;
  logic                       cfg_wr;
  logic                       in_acc;
  logic                       mem_wr;
  logic [PTR_W-1:0]           wr_slot;
  logic                       emit;
  logic                       out_load;
  logic                       m_vld_q;
  logic [SB-1:0]              m_dat_q;
  logic [SB-1:0]              red_val;
  swm_pkg::cell_ctrl_t        ctrl;

  logic          c_vld [MAX_WINDOW];
  logic [SB-1:0] c_val [MAX_WINDOW];
  logic          c_a   [MAX_WINDOW];
  logic          c_b   [MAX_WINDOW];
  logic [SB-1:0] c_tap [MAX_WINDOW];

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == swm_pkg::REG_WINDOW_LEN);
  assign prdata = (psel && (paddr[2] == swm_pkg::REG_WINDOW_LEN)) ?
                  {{(swm_pkg::APB_DW - swm_pkg::LEN_W){1'b0}}, len_q} : '0;

  // Effective length: zero as one, saturate at the store depth
  always_comb begin
    if (len_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(len_q) > 32'(MAX_WINDOW)) begin
      eff_len = CNT_W'(MAX_WINDOW);
    end else begin
      eff_len = CNT_W'(len_q);
    end
  end

  // Rank of the median inside the sorted row: ceil(len/2) - 1
  assign kidx = (eff_len - CNT_W'(1)) >> 1;

  // Handshakes
  assign s_axis_tready = (state_q == swm_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == swm_pkg::ST_OUT) && (!m_vld_q || m_axis_tready);

  // Window bookkeeping for the update step
  assign fill_inc   = fill_q + CNT_W'(1);
  assign oldest_inc = CNT_W'(oldest_q) + CNT_W'(1);
  assign emit       = full_q || (fill_inc == eff_len);
  assign mem_wr     = (state_q == swm_pkg::ST_UPD);
  assign wr_slot    = full_q ? oldest_q : fill_q[PTR_W-1:0];

  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    if (cfg_wr) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (state_q == swm_pkg::ST_UPD) begin
      if (full_q) begin
        oldest_d = (oldest_inc == eff_len) ? '0 : PTR_W'(oldest_inc);
      end else begin
        fill_d   = fill_inc;
        oldest_d = '0;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      swm_pkg::ST_IDLE: if (in_acc) state_d = swm_pkg::ST_UPD;
      swm_pkg::ST_UPD:  state_d = emit ? swm_pkg::ST_RED : swm_pkg::ST_IDLE;
      swm_pkg::ST_RED:  state_d = swm_pkg::ST_OUT;
      swm_pkg::ST_OUT:  if (out_load) state_d = swm_pkg::ST_IDLE;
      default:          state_d = swm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swm_pkg::ST_IDLE;
      len_q    <= swm_pkg::LEN_W'(3);
      fill_q   <= '0;
      oldest_q <= '0;
      full_q   <= 1'b0;
      m_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      if (cfg_wr) begin
        len_q <= pwdata[swm_pkg::LEN_W-1:0];
      end
      if (in_acc) begin
        full_q <= (fill_q == eff_len);
      end
      if (out_load) begin
        m_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
    end
  end

  // Capture the sample, load the median word
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q <= s_axis_tdata[SB-1:0];
    end
    if (out_load) begin
      m_dat_q <= red_val;
    end
  end

  // Sample store: read the oldest slot on accept, write the new sample on update
  always_ff @(posedge clk_i) begin
    if (mem_wr) begin
      mem[wr_slot] <= smp_q;
    end
    if (in_acc) begin
      rd_q <= mem[oldest_q];
    end
  end

  // Broadcast control to the row
  always_comb begin
    ctrl.flush = cfg_wr;
    ctrl.upd   = (state_q == swm_pkg::ST_UPD);
    ctrl.del   = full_q;
    ctrl.up    = (smp_q >= rd_q);
  end

  // Sorted cell row
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic          p_vld, n_vld;
    logic [SB-1:0] p_val, n_val;
    logic          p_a, p_b, n_b;

    if (i == 0) begin : g_first
      assign p_vld = 1'b0;
      assign p_val = '0;
      assign p_a   = 1'b0;
      assign p_b   = 1'b0;
    end else begin : g_mid_lo
      assign p_vld = c_vld[i-1];
      assign p_val = c_val[i-1];
      assign p_a   = c_a[i-1];
      assign p_b   = c_b[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign n_vld = 1'b0;
      assign n_val = '0;
      assign n_b   = 1'b1;
    end else begin : g_mid_hi
      assign n_vld = c_vld[i+1];
      assign n_val = c_val[i+1];
      assign n_b   = c_b[i+1];
    end

    swm_cell #(
      .W (SB)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .sample_i  (smp_q),
      .vold_i    (rd_q),
      .prv_vld_i (p_vld),
      .prv_val_i (p_val),
      .prv_a_i   (p_a),
      .prv_b_i   (p_b),
      .nxt_vld_i (n_vld),
      .nxt_val_i (n_val),
      .nxt_b_i   (n_b),
      .vld_o     (c_vld[i]),
      .val_o     (c_val[i]),
      .a_o       (c_a[i]),
      .b_o       (c_b[i])
    );

    // Only the median cell drives its tap
    assign c_tap[i] = (c_vld[i] && (kidx == CNT_W'(i))) ? c_val[i] : '0;
  end

  swm_tap_reduce #(
    .N (MAX_WINDOW),
    .W (SB)
  ) u_reduce (
    .clk_i (clk_i),
    .tap_i (c_tap),
    .val_o (red_val)
  );

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = TDATA_W'(m_dat_q);

endmodule

@@ tb/sv/sliding_window_median_core_test.sv @@
// ----------------------------------------------------------------------------
// Sliding window median core testbench
// Streams samples through the core under several window lengths, tracks the
// window and its value histogram alongside, and compares every median word
// in order. Both stream sides idle at random; the receiver also holds off for
// a long stretch so the core backs up into its input.
// ----------------------------------------------------------------------------
module sliding_window_median_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_MAX      = 256;
  localparam int unsigned VAL_SPAN     = 256;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned SHOWN_FAULTS = 10;

  localparam logic [swm_pkg::APB_AW-1:0] ADDR_WINDOW_LEN = {swm_pkg::REG_WINDOW_LEN, 2'b00};
  localparam logic [swm_pkg::APB_AW-1:0] ADDR_UNMAPPED   = {~swm_pkg::REG_WINDOW_LEN, 2'b00};

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata  = '0;   // [7:0] sample
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;         // [7:0] median
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [swm_pkg::APB_AW-1:0] paddr         = '0;
  logic [swm_pkg::APB_DW-1:0] pwdata        = '0;
  logic [swm_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  // Shadow of the window: samples, value histogram, fill level, oldest slot
  logic [7:0]  win_samples [WIN_MAX];
  int unsigned value_tally [VAL_SPAN];
  int unsigned win_fill;
  int unsigned win_oldest;
  int unsigned win_span;
  logic [7:0]  median_q [$];

  int unsigned fault_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          src_steady   = 1'b0;
  bit          sink_steady  = 1'b0;
  int unsigned hold_req     = 0;
  int unsigned hold_served  = 0;
  int unsigned hold_left    = 0;

  sliding_window_median_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= SHOWN_FAULTS) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
  endfunction

  // Clamp the length into 1..WIN_MAX and empty the window
  function automatic void load_window_len(input logic [8:0] len);
    win_span   = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
    win_fill   = 0;
    win_oldest = 0;
    foreach (value_tally[v]) value_tally[v] = 0;
  endfunction

  // Evict the oldest sample once full, insert the new one, queue the median
  function automatic void take_sample(input logic [7:0] s);
    logic [7:0]  evicted;
    int unsigned rank;
    int unsigned acc;
    if (win_fill < win_span) begin
      win_samples[win_fill] = s;
      value_tally[s]++;
      win_fill++;
      if (win_fill < win_span) return;
      win_oldest = 0;
    end else begin
      evicted = win_samples[win_oldest];
      if (value_tally[evicted] > 0) value_tally[evicted]--;
      win_samples[win_oldest] = s;
      value_tally[s]++;
      win_oldest = (win_oldest + 1) % win_span;
    end
    rank = (win_span + 1) / 2;
    acc  = 0;
    for (int v = 0; v < VAL_SPAN; v++) begin
      acc += value_tally[v];
      if (acc >= rank) begin
        median_q.push_back(8'(v));
        return;
      end
    end
  endfunction

  function automatic void check_median(input logic [7:0] got);
    logic [7:0] want;
    if (median_q.size() == 0) begin
      report_fault($sformatf("median %0d with none pending", got));
    end else begin
      want = median_q.pop_front();
      if (got !== want) begin
        report_fault($sformatf("median expected %0d, got %0d", want, got));
      end
    end
  endfunction

  // Observe register writes, accepted samples and median words at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW_LEN) begin
        load_window_len(pwdata[8:0]);
      end
      if (s_axis_tvalid && s_axis_tready) take_sample(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_median(m_axis_tdata);
    end
  end

  // Receiver: random stalls, steady stretches, and a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_req) begin
      hold_served   <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 33);
    end
  end

  // Abort when nothing moves on any port for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [7:0] s);
    while (!src_steady && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait for every pending median, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [swm_pkg::APB_AW-1:0] addr,
                           input logic [swm_pkg::APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [swm_pkg::APB_AW-1:0] addr,
                                input logic [swm_pkg::APB_DW-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      report_fault($sformatf("window_len read expected %0d, got %0d", want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Change the window length on an idle core; upper data bits are don't-care
  task automatic set_window_len(input logic [8:0] len);
    settle();
    apb_write(ADDR_WINDOW_LEN, {23'($urandom()), len});
    apb_read_check(ADDR_WINDOW_LEN, {23'b0, len});
  endtask

  function automatic logic [7:0] pick_sample(input bit narrow, input logic [7:0] base);
    return narrow ? 8'(base + $urandom_range(3)) : 8'($urandom_range(255));
  endfunction

  task automatic test_default_window();
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd128);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd0);
    send_sample(8'd7);
  endtask

  // Zero means a single sample; two takes the lower of the pair
  task automatic test_window_extremes();
    set_window_len(9'd0);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd9);
    set_window_len(9'd1);
    send_sample(8'd255);
    send_sample(8'd0);
    set_window_len(9'd2);
    send_sample(8'd10);
    send_sample(8'd20);
    send_sample(8'd20);
    send_sample(8'd10);
  endtask

  // A write outside window_len must neither flush nor retune the window
  task automatic test_unmapped_register();
    set_window_len(9'd5);
    send_sample(8'd50);
    send_sample(8'd40);
    send_sample(8'd30);
    settle();
    apb_write(ADDR_UNMAPPED, 32'd7);
    send_sample(8'd20);
    send_sample(8'd10);
    send_sample(8'd255);
    send_sample(8'd255);
    send_sample(8'd0);
  endtask

  task automatic test_random_windows();
    logic [8:0] len;
    bit         narrow;
    logic [7:0] base;
    for (int phase = 0; phase < 6; phase++) begin
      len    = (phase == 3) ? 9'd0 : 9'($urandom_range(16, 1));
      narrow = 1'($urandom_range(1));
      base   = 8'($urandom_range(252));
      set_window_len(len);
      repeat (20) send_sample(pick_sample(narrow, base));
    end
  endtask

  // Hold the receiver off while samples keep coming so the core backs up
  task automatic test_backpressure();
    set_window_len(9'd4);
    src_steady = 1'b1;
    hold_req  <= hold_req + 1;
    repeat (50) send_sample(pick_sample(1'b0, 8'd0));
    src_steady = 1'b0;
  endtask

  task automatic test_no_idle();
    set_window_len(9'd3);
    src_steady   = 1'b1;
    sink_steady <= 1'b1;
    repeat (40) send_sample(pick_sample(1'($urandom_range(1)), 8'd100));
    src_steady   = 1'b0;
    sink_steady <= 1'b0;
  endtask

  // A length beyond the largest window must saturate to it; fill it and slide
  task automatic test_full_window();
    set_window_len(9'd511);
    repeat (340) send_sample(pick_sample($urandom_range(3) == 0, 8'd200));
  endtask

  initial begin
    load_window_len(9'd3);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_window_extremes();
    test_unmapped_register();
    test_random_windows();
    test_backpressure();
    test_no_idle();
    test_full_window();

    settle();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/swm_pkg.sv
design/swm_cell.sv
design/swm_tap_reduce.sv
design/sliding_window_median_core.sv
tb/sv/sliding_window_median_core_test.sv
